[rtl/core/byte_fifo_bit_reader_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the byte FIFO bit reader core.
// The macros expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef BYTE_FIFO_BIT_READER_CORE_ASSERT_SVH
`define BYTE_FIFO_BIT_READER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BFBR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BFBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bfbr_pkg.sv]
// ----------------------------------------------------------------------------
// bfbr_pkg
// Shared types and constants of the byte FIFO bit reader core.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbr_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 1024;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned BITCNT_W       = 5;
    localparam int unsigned VALUE_W        = 24;
    localparam int unsigned REMAIN_W       = 14;
    localparam int unsigned BUF_W          = 32;
    localparam int unsigned HELD_W         = 6;
    localparam int unsigned MAX_READ_BITS  = 24;

    localparam int unsigned CQ_DEPTH = 2;
    localparam int unsigned CQ_PTR_W = 1;
    localparam int unsigned CQ_CNT_W = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic ORDER_MSB = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_READ,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [BYTE_W-1:0]     data_byte;
        logic [BITCNT_W-1:0]   bit_count;
        logic                  consume;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } back_state_t;

    function automatic logic [BUF_W-1:0] low_mask(input logic [HELD_W-1:0] n);
        logic [BUF_W:0] m;
        m = ({{BUF_W{1'b0}}, 1'b1} << n) - {{BUF_W{1'b0}}, 1'b1};
        return m[BUF_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/bfbr_cmd_queue.sv]
// ----------------------------------------------------------------------------
// bfbr_cmd_queue
// Short queue of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbr_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bfbr_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bfbr_pkg::cmd_t pop_cmd
);
    import bfbr_pkg::*;

    cmd_t                entry_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg;
    logic [CQ_CNT_W-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CQ_CNT_W'(CQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bfbr_front.sv]
// ----------------------------------------------------------------------------
// bfbr_front
// Accepts input transactions and classifies them as push, read or invalid read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbr_front
(
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [bfbr_pkg::BYTE_W-1:0]    data_byte,
    input  logic [bfbr_pkg::BITCNT_W-1:0]  bit_count,
    input  logic                           consume,
    output logic                           q_valid,
    input  logic                           q_ready,
    output bfbr_pkg::cmd_t                 q_cmd
);
    import bfbr_pkg::*;

    cmd_kind_t kind;

    always_comb
    begin
        if (mode == MODE_PUSH)
        begin
            kind = CMD_PUSH;
        end
        else if (bit_count > BITCNT_W'(MAX_READ_BITS))
        begin
            kind = CMD_BAD;
        end
        else
        begin
            kind = CMD_READ;
        end
    end

    assign q_cmd.kind      = kind;
    assign q_cmd.data_byte = data_byte;
    assign q_cmd.bit_count = bit_count;
    assign q_cmd.consume   = consume;
    assign q_valid         = in_valid;
    assign in_stall        = !q_ready;

endmodule

`default_nettype wire

[rtl/core/bfbr_back.sv]
// ----------------------------------------------------------------------------
// bfbr_back
// Byte FIFO storage, bit buffer and result register; executes one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_fifo_bit_reader_core_assert.svh"

module bfbr_back
#(
    parameter int unsigned FIFO_DEPTH = bfbr_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_bit_order,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  bfbr_pkg::cmd_t                 cmd,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bfbr_pkg::VALUE_W-1:0]   value,
    output logic                           ok,
    output logic [bfbr_pkg::REMAIN_W-1:0]  remaining_bits
);
    import bfbr_pkg::*;

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned RS_W  = ((CNT_W + 4) > REMAIN_W) ? (CNT_W + 4) : REMAIN_W;

    logic [BYTE_W-1:0]   mem [FIFO_DEPTH];
    logic [BYTE_W-1:0]   mem_rd_data_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    cmd_t                cur_reg;
    cmd_t                cur_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [BUF_W-1:0]    buf_reg;
    logic [BUF_W-1:0]    buf_next;
    logic [HELD_W-1:0]   held_bits_reg;
    logic [HELD_W-1:0]   held_bits_next;
    logic                bit_order_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  res_value;
    logic                ok_reg;
    logic                res_ok;
    logic [REMAIN_W-1:0] remain_reg;
    logic [REMAIN_W-1:0] res_remain;
    logic [RS_W-1:0]     remain_sum;

    logic                need_fetch;
    logic                out_free;
    logic                fetch;
    logic                load;
    logic                commit;
    logic                fifo_full;
    logic                mem_we;
    logic [HELD_W-1:0]   req_bits;
    logic [HELD_W-1:0]   msb_shift;
    logic [BUF_W-1:0]    msb_field;
    logic [BUF_W-1:0]    field;

    assign fifo_full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign req_bits   = {1'b0, cur_reg.bit_count};
    assign need_fetch = (cur_reg.kind == CMD_READ) && (req_bits > held_bits_reg)
                        && (count_reg != '0);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (need_fetch)
                begin
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EXEC;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        fetch     = 1'b0;
        load      = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_EXEC:
            begin
                fetch  = need_fetch;
                commit = !need_fetch && out_free;
            end
            ST_LOAD:
            begin
                load = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign msb_shift = held_bits_reg - req_bits;
    assign msb_field = buf_reg >> msb_shift[4:0];
    assign field     = ((bit_order_reg == ORDER_MSB) ? msb_field : buf_reg) & low_mask(req_bits);

    always_comb
    begin
        cur_next       = (cmd_ready && cmd_valid) ? cmd : cur_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        buf_next       = buf_reg;
        held_bits_next = held_bits_reg;
        res_value      = '0;
        res_ok         = 1'b0;
        mem_we         = 1'b0;

        if (fetch)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end

        if (load)
        begin
            held_bits_next = held_bits_reg + HELD_W'(8);
            if (bit_order_reg == ORDER_MSB)
            begin
                buf_next = {buf_reg[BUF_W-BYTE_W-1:0], mem_rd_data_reg};
            end
            else
            begin
                buf_next = buf_reg | (BUF_W'(mem_rd_data_reg) << held_bits_reg[4:0]);
            end
        end

        if (commit)
        begin
            case (cur_reg.kind)
                CMD_PUSH:
                begin
                    if (!fifo_full)
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ?
                                      '0 : wr_ptr_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                        res_ok      = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (req_bits <= held_bits_reg)
                    begin
                        res_ok    = 1'b1;
                        res_value = field[VALUE_W-1:0];
                        if (cur_reg.consume)
                        begin
                            held_bits_next = held_bits_reg - req_bits;
                            if (bit_order_reg == ORDER_MSB)
                            begin
                                buf_next = buf_reg & low_mask(held_bits_next);
                            end
                            else
                            begin
                                buf_next = (buf_reg >> cur_reg.bit_count)
                                           & low_mask(held_bits_next);
                            end
                        end
                    end
                end
                default:
                begin
                    res_ok = 1'b0;
                end
            endcase
        end

        remain_sum = (RS_W'(count_next) << 3) + RS_W'(held_bits_next);
        res_remain = remain_sum[REMAIN_W-1:0];
    end

    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            buf_reg       <= '0;
            held_bits_reg <= '0;
            bit_order_reg <= ORDER_MSB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            buf_reg       <= buf_next;
            held_bits_reg <= held_bits_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                bit_order_reg <= cfg_bit_order;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (commit)
        begin
            value_reg  <= res_value;
            ok_reg     <= res_ok;
            remain_reg <= res_remain;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= cur_reg.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            mem_rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = value_reg;
    assign ok             = ok_reg;
    assign remaining_bits = remain_reg;

    `BFBR_ASSERT_NOW(a_held_range, 1'b1, held_bits_reg < HELD_W'(32), "Held bit count above 31.")
    `BFBR_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "FIFO count overflow.")
    `BFBR_ASSERT_NOW(a_fetch_nonempty, fetch, count_reg != '0, "Fetch from an empty FIFO.")
    `BFBR_ASSERT_NEXT(a_fetch_load, fetch, state_reg == ST_LOAD, "Fetch not followed by a load.")
    `BFBR_ASSERT_NEXT(a_commit_shown, commit, out_valid_reg, "Committed result not presented.")

endmodule

`default_nettype wire

[rtl/core/byte_fifo_bit_reader_core.sv]
// A transaction passes the command queue and the back end's idle and execute states; each
// FIFO byte moved adds a registered read of the FIFO memory port and a bit-buffer load.
// A read moves at most three bytes; the back end holds new commands until the last commits.
// Reset: asynchronous and active low; clears the FIFO, the bit buffer and the bit order.
// The FIFO memory contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// byte_fifo_bit_reader_core
// Bitstream reader fed by a byte FIFO, with MSB-first or LSB-first packing.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_fifo_bit_reader_core
#(
    parameter int unsigned FIFO_DEPTH = bfbr_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [bfbr_pkg::BYTE_W-1:0]    data_byte,
    input  logic [bfbr_pkg::BITCNT_W-1:0]  bit_count,
    input  logic                           consume,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bfbr_pkg::VALUE_W-1:0]   value,
    output logic                           ok,
    output logic [bfbr_pkg::REMAIN_W-1:0]  remaining_bits
);
    import bfbr_pkg::*;

    logic q_in_valid;
    logic q_in_ready;
    cmd_t q_in_cmd;
    logic q_out_valid;
    logic q_out_ready;
    cmd_t q_out_cmd;
    logic cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bfbr_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .data_byte (data_byte),
        .bit_count (bit_count),
        .consume   (consume),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_cmd     (q_in_cmd)
    );

    bfbr_cmd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_cmd   (q_in_cmd),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_cmd    (q_out_cmd)
    );

    bfbr_back
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_bit_order  (cfg_data),
        .cmd_valid      (q_out_valid),
        .cmd_ready      (q_out_ready),
        .cmd            (q_out_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .ok             (ok),
        .remaining_bits (remaining_bits)
    );

endmodule

`default_nettype wire
